FILE: design/bbom_pkg.sv
// shared types and constants for the box blur occlusion modulate block
package bbom_pkg;

   localparam int OCC_W       = 16;
   localparam int CH_W        = 16;
   localparam int COLOR_W     = 3 * CH_W;
   localparam int COLSUM_W    = OCC_W + 2;
   localparam int SUM_W       = OCC_W + 4;
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int ROW_W       = 13;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam int WIDTH_DEFAULT  = 640;
   localparam int HEIGHT_DEFAULT = 480;

   // floor(x / 9) as (x * RECIP) >> RECIP_SHIFT, exact for x below 2**SUM_W
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1864136);

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      color_type        color;
      logic             frame_last;
      logic             run_last;
   } rec_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic            frame_last;
      logic            run_last;
   } res_type;

   typedef struct packed {
      logic       hold;
      logic [2:0] inflight;
   } win_status_type;

endpackage

FILE: design/bbom_intf.sv
// stream and register write channel interfaces
interface bbom_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [bbom_pkg::OCC_W-1:0] occlusion;
   logic [bbom_pkg::CH_W-1:0]  red;
   logic [bbom_pkg::CH_W-1:0]  green;
   logic [bbom_pkg::CH_W-1:0]  blue;

   modport source (output valid, kind, occlusion, red, green, blue, input ready);
   modport sink (input valid, kind, occlusion, red, green, blue, output ready);
endinterface

interface bbom_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bbom_pkg::CH_W-1:0] red_out;
   logic [bbom_pkg::CH_W-1:0] green_out;
   logic [bbom_pkg::CH_W-1:0] blue_out;
   logic                      frame_last;
   logic                      run_last;

   modport source (output valid, red_out, green_out, blue_out, frame_last, run_last,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, frame_last, run_last,
                 output ready);
endinterface

interface bbom_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bbom_pkg::CSR_INDEX_W-1:0] index;
   logic [bbom_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: design/box_blur_occlusion_modulate_top.sv
// top level of the 3x3 occlusion box blur and colour modulation block
//
// Pixels enter in raster order, one per clock. Each result is the colour of the pixel one
// row and one column behind the input, scaled by the floor of the 3x3 occlusion average
// with edges replicated; row 0 gives no results and one padding row of flush transfers
// after the frame drains the last row. Throughput is one transfer per clock, except that a
// transfer at the last column of a row (for widths above one) yields two results and the
// input then takes no transfer while the second result waits, as the single result path
// carries one result per clock. Line buffers are on-chip memories of MAX_WIDTH entries,
// each read once per transfer. Results pass the window, record and average registers to an
// eight-entry queue that absorbs output stalls; req.ready drops on that hold and when the
// queue could overflow. Register writes are always taken and apply from the next transfer.
module box_blur_occlusion_modulate_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic    clock,
   input  logic    reset,
   bbom_req_if.sink   req,
   bbom_rsp_if.source rsp,
   bbom_csr_if.sink   csr
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = bbom_pkg::ROW_W;
   localparam int WIDTH_RESET  = (bbom_pkg::WIDTH_DEFAULT < MAX_WIDTH)
                               ? bbom_pkg::WIDTH_DEFAULT : MAX_WIDTH;
   localparam int HEIGHT_RESET = (bbom_pkg::HEIGHT_DEFAULT < MAX_HEIGHT)
                               ? bbom_pkg::HEIGHT_DEFAULT : MAX_HEIGHT;

   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] height_ff, height_in;
   logic [13:0]   w_req, w_eff, h_req, h_eff;

   logic                     accept;
   bbom_pkg::color_type      in_color;
   logic                     rec_valid;
   bbom_pkg::rec_type        rec;
   bbom_pkg::win_status_type win_status;
   logic                     avg_valid;
   logic                     res_valid;
   bbom_pkg::res_type        res;
   bbom_pkg::res_type        head;
   logic [bbom_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic [4:0]               committed;

   // register writes, values clamped to the supported range
   assign csr.ready = 1'b1;
   assign w_req = 14'(csr.data[bbom_pkg::FW_W-1:0]);
   assign h_req = 14'(csr.data[bbom_pkg::FH_W-1:0]);

   always_comb begin
      if (w_req == '0) begin
         w_eff = 14'd1;
      end else if (w_req > 14'(MAX_WIDTH)) begin
         w_eff = 14'(MAX_WIDTH);
      end else begin
         w_eff = w_req;
      end
      if (h_req == '0) begin
         h_eff = 14'd1;
      end else if (h_req > 14'(MAX_HEIGHT)) begin
         h_eff = 14'(MAX_HEIGHT);
      end else begin
         h_eff = h_req;
      end
   end

   always_comb begin
      last_col_in = last_col_ff;
      height_in   = height_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            bbom_pkg::REG_FRAME_WIDTH: begin
               last_col_in = CW'(w_eff - 14'd1);
            end
            bbom_pkg::REG_FRAME_HEIGHT: begin
               height_in = RW'(h_eff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= CW'(WIDTH_RESET - 1);
         height_ff   <= RW'(HEIGHT_RESET);
      end else begin
         last_col_ff <= last_col_in;
         height_ff   <= height_in;
      end
   end

   // input flow control against the output queue
   assign committed = 5'(fifo_count) + 5'(win_status.inflight) + 5'(avg_valid);
   assign req.ready = !win_status.hold && (committed <= 5'(bbom_pkg::FIFO_DEPTH - 2));
   assign accept    = req.valid && req.ready;

   assign in_color.red   = req.red;
   assign in_color.green = req.green;
   assign in_color.blue  = req.blue;

   bbom_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .occlusion (req.occlusion),
      .color     (in_color),
      .last_col  (last_col_ff),
      .height    (height_ff),
      .rec_valid (rec_valid),
      .rec       (rec),
      .status    (win_status)
   );

   bbom_modulate u_modulate (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec       (rec),
      .avg_valid (avg_valid),
      .res_valid (res_valid),
      .res       (res)
   );

   bbom_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (rsp.ready),
      .head_valid (rsp.valid),
      .head_data  (head),
      .count      (fifo_count)
   );

   assign rsp.red_out    = head.red_out;
   assign rsp.green_out  = head.green_out;
   assign rsp.blue_out   = head.blue_out;
   assign rsp.frame_last = head.frame_last;
   assign rsp.run_last   = head.run_last;

endmodule

FILE: design/bbom_window.sv
// raster counters, line buffers and 3x3 window producing box sums
module bbom_window #(
   parameter int MAX_WIDTH = 2048,
   parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [bbom_pkg::OCC_W-1:0]    occlusion,
   input  bbom_pkg::color_type           color,
   input  logic [CW-1:0]                 last_col,
   input  logic [bbom_pkg::ROW_W-1:0]    height,
   output logic                          rec_valid,
   output bbom_pkg::rec_type             rec,
   output bbom_pkg::win_status_type      status
);

   localparam int OW = bbom_pkg::OCC_W;
   localparam int SW = bbom_pkg::SUM_W;
   localparam int RW = bbom_pkg::ROW_W;

   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;

   logic [OW-1:0]       above_mem  [MAX_WIDTH];
   logic [OW-1:0]       center_mem [MAX_WIDTH];
   bbom_pkg::color_type color_mem  [MAX_WIDTH];

   logic [OW-1:0]       above_rd_ff;
   logic [OW-1:0]       center_rd_ff;
   bbom_pkg::color_type color_rd_ff;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_idx_ff;
   logic [OW-1:0] s1_occ_ff;
   logic          s1_flush_ff;
   logic          s1_row0_ff;
   logic          s1_row1_ff;
   logic          s1_first_ff;
   logic          s1_last_ff;
   logic          s1_two_ff;
   logic [1:0]    s1_nres_ff;
   logic          s1_fwd_ff;
   logic [OW-1:0] s1_fwd_data_ff;

   logic [bbom_pkg::COLSUM_W-1:0] w1_ff, w1_in;
   logic [bbom_pkg::COLSUM_W-1:0] w2_ff, w2_in;
   bbom_pkg::color_type           cw_ff, cw_in;

   logic              rec_valid_ff, rec_valid_in;
   bbom_pkg::rec_type rec_ff, rec_in;
   logic              pend_valid_ff, pend_valid_in;
   bbom_pkg::rec_type pend_ff;

   logic a_flush, a_last, a_row0, a_first;
   logic [1:0] a_nres;

   logic [OW-1:0] b_mid, b_above, b_top, b_bot;
   logic [bbom_pkg::COLSUM_W-1:0] b_col;
   logic b_wr, b_e1, b_e2;
   logic [SW-1:0] b_sum1, b_sum2;
   bbom_pkg::rec_type b_rec1, b_rec2;

   // input stage decode
   assign a_flush = row_ff >= height;
   assign a_last  = col_ff >= last_col;
   assign a_row0  = row_ff == '0;
   assign a_first = col_ff == '0;
   always_comb begin
      if (a_row0) begin
         a_nres = 2'd0;
      end else begin
         a_nres = {1'b0, !a_first} + {1'b0, a_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (a_last) begin
            col_ff <= '0;
            row_ff <= a_flush ? '0 : row_ff + RW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // line buffers
   always_ff @(posedge clock) begin
      if (accept) begin
         center_rd_ff <= center_mem[col_ff];
         color_rd_ff  <= color_mem[col_ff];
         if (!a_flush) begin
            center_mem[col_ff] <= occlusion;
            color_mem[col_ff]  <= color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         above_rd_ff <= above_mem[col_ff];
      end
      if (b_wr) begin
         above_mem[s1_idx_ff] <= b_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff      <= col_ff;
         s1_occ_ff      <= occlusion;
         s1_flush_ff    <= a_flush;
         s1_row0_ff     <= a_row0;
         s1_row1_ff     <= row_ff == RW'(1);
         s1_first_ff    <= a_first;
         s1_last_ff     <= a_last;
         s1_two_ff      <= !a_row0 && !a_first && a_last;
         s1_nres_ff     <= a_nres;
         // row above is written back from the window stage, so catch a same-column read
         s1_fwd_ff      <= b_wr && (s1_idx_ff == col_ff);
         s1_fwd_data_ff <= b_mid;
      end
   end

   // window stage
   assign b_mid   = center_rd_ff;
   assign b_above = s1_fwd_ff ? s1_fwd_data_ff : above_rd_ff;
   assign b_top   = s1_row1_ff ? b_mid : b_above;
   assign b_bot   = s1_flush_ff ? b_mid : s1_occ_ff;
   assign b_wr    = s1_valid_ff && !s1_row0_ff && !s1_flush_ff;
   assign b_col   = bbom_pkg::COLSUM_W'(b_top) + bbom_pkg::COLSUM_W'(b_mid)
                  + bbom_pkg::COLSUM_W'(b_bot);
   assign b_e1    = s1_valid_ff && !s1_row0_ff && !s1_first_ff;
   assign b_e2    = s1_valid_ff && !s1_row0_ff && s1_last_ff;

   assign b_sum1 = SW'(w1_ff) + SW'(w2_ff) + SW'(b_col);
   assign b_sum2 = SW'(s1_first_ff ? b_col : w2_ff) + (SW'(b_col) << 1);

   always_comb begin
      b_rec1.sum        = b_sum1;
      b_rec1.color      = cw_ff;
      b_rec1.frame_last = 1'b0;
      b_rec1.run_last   = !s1_last_ff;
      b_rec2.sum        = b_sum2;
      b_rec2.color      = color_rd_ff;
      b_rec2.frame_last = s1_flush_ff;
      b_rec2.run_last   = 1'b1;
   end

   always_comb begin
      w1_in = w1_ff;
      w2_in = w2_ff;
      cw_in = cw_ff;
      if (s1_valid_ff && !s1_row0_ff) begin
         w1_in = s1_first_ff ? b_col : w2_ff;
         w2_in = b_col;
         cw_in = color_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      cw_ff <= cw_in;
   end

   // result records, second one of a row end waits in the pending register
   always_comb begin
      rec_valid_in  = b_e1 || b_e2 || pend_valid_ff;
      pend_valid_in = b_e1 && b_e2;
      if (b_e1) begin
         rec_in = b_rec1;
      end else if (b_e2) begin
         rec_in = b_rec2;
      end else begin
         rec_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff  <= rec_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (pend_valid_in) begin
         pend_ff <= b_rec2;
      end
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

   always_comb begin
      status.hold     = s1_valid_ff && s1_two_ff;
      status.inflight = (s1_valid_ff ? {1'b0, s1_nres_ff} : 3'd0)
                      + {2'b0, pend_valid_ff} + {2'b0, rec_valid_ff};
   end

endmodule

FILE: design/bbom_modulate.sv
// divide box sum by nine and scale the colour channels
module bbom_modulate (
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_valid,
   input  bbom_pkg::rec_type rec,
   output logic              avg_valid,
   output logic              res_valid,
   output bbom_pkg::res_type res
);

   localparam int OW = bbom_pkg::OCC_W;
   localparam int PW = bbom_pkg::SUM_W + bbom_pkg::RECIP_W;
   localparam int MW = bbom_pkg::CH_W + OW;

   logic [PW-1:0] quot_prod;

   logic                avg_valid_ff;
   logic [OW-1:0]       avg_ff;
   bbom_pkg::color_type color_ff;
   logic                frame_last_ff;
   logic                run_last_ff;

   logic [MW-1:0] prod_r, prod_g, prod_b;

   function automatic logic [bbom_pkg::CH_W-1:0] sat_scale(input logic [MW-1:0] p);
      logic [bbom_pkg::CH_W-1:0] v;
      if (p[MW-1]) begin
         v = '1;
      end else begin
         v = p[MW-2 -: bbom_pkg::CH_W];
      end
      return v;
   endfunction

   assign quot_prod = PW'(rec.sum) * PW'(bbom_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else begin
         avg_valid_ff <= rec_valid;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff        <= quot_prod[bbom_pkg::RECIP_SHIFT +: OW];
      color_ff      <= rec.color;
      frame_last_ff <= rec.frame_last;
      run_last_ff   <= rec.run_last;
   end

   assign prod_r = MW'(color_ff.red) * MW'(avg_ff);
   assign prod_g = MW'(color_ff.green) * MW'(avg_ff);
   assign prod_b = MW'(color_ff.blue) * MW'(avg_ff);

   always_comb begin
      res.red_out    = sat_scale(prod_r);
      res.green_out  = sat_scale(prod_g);
      res.blue_out   = sat_scale(prod_b);
      res.frame_last = frame_last_ff;
      res.run_last   = run_last_ff;
   end

   assign avg_valid = avg_valid_ff;
   assign res_valid = avg_valid_ff;

endmodule

FILE: design/bbom_result_fifo.sv
// small result queue in front of the output channel
module bbom_result_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  bbom_pkg::res_type                 push_data,
   input  logic                              pop,
   output logic                              head_valid,
   output bbom_pkg::res_type                 head_data,
   output logic [bbom_pkg::FIFO_CNT_W-1:0]   count
);

   localparam int PTR_W = bbom_pkg::FIFO_PTR_W;
   localparam int CNT_W = bbom_pkg::FIFO_CNT_W;

   bbom_pkg::res_type  entry_ff [bbom_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the occlusion box blur and colour modulation block
`timescale 1ns / 100ps

module tb_top;
   import bbom_pkg::*;

   localparam int MAX_W        = 2048;
   localparam int MAX_H        = 4096;
   localparam int SETTLE_COUNT = 24;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic             kind;
      logic [OCC_W-1:0] occlusion;
      color_type        color;
   } pixel_type;

   logic clock;
   logic reset;

   bbom_req_if req_if ();
   bbom_rsp_if rsp_if ();
   bbom_csr_if csr_if ();

   box_blur_occlusion_modulate_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // blur state mirrored from the block
   logic [FW_W-1:0]  cfg_width;
   logic [FH_W-1:0]  cfg_height;
   logic [OCC_W-1:0] occl_above [MAX_W];
   logic [OCC_W-1:0] occl_center [MAX_W];
   color_type        color_center [MAX_W];
   logic [OCC_W-1:0] occl_win [9];
   color_type        color_win [2];
   int unsigned      col_cnt;
   int unsigned      row_cnt;

   res_type     modulated_colors [$];
   res_type     oldest_color;
   int          error_count  = 0;
   int          pixels_sent  = 0;
   int unsigned cycle_count  = 0;
   int          src_idle_pct = 0;
   int          sink_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   function automatic int unsigned eff_width();
      int unsigned w;
      w = 32'(cfg_width);
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = 32'(cfg_height);
      if (h < 1) h = 1;
      if (h > MAX_H) h = MAX_H;
      return h;
   endfunction

   function automatic logic [CH_W-1:0] scale_channel(logic [CH_W-1:0] level, int unsigned avg);
      longint unsigned prod;
      prod = 64'(level);
      prod = (prod * 64'(avg)) >> 15;
      return (prod > 65535) ? 16'hFFFF : prod[CH_W-1:0];
   endfunction

   function automatic void shift_window(logic [OCC_W-1:0] top, logic [OCC_W-1:0] mid,
                                        logic [OCC_W-1:0] bot, color_type col);
      int k;
      for (k = 0; k < 6; k++) occl_win[k] = occl_win[k + 3];
      occl_win[6] = top;
      occl_win[7] = mid;
      occl_win[8] = bot;
      color_win[0] = color_win[1];
      color_win[1] = col;
   endfunction

   function automatic res_type blur_result(bit frame_end);
      int unsigned total;
      int unsigned avg;
      int k;
      res_type res;
      total = 0;
      for (k = 0; k < 9; k++) total += 32'(occl_win[k]);
      avg = total / 9;
      res.red_out    = scale_channel(color_win[0].red, avg);
      res.green_out  = scale_channel(color_win[0].green, avg);
      res.blue_out   = scale_channel(color_win[0].blue, avg);
      res.frame_last = frame_end;
      res.run_last   = 1'b0;
      return res;
   endfunction

   function automatic void reset_blur_state();
      int k;
      cfg_width  = FW_W'(WIDTH_DEFAULT);
      cfg_height = FH_W'(HEIGHT_DEFAULT);
      for (k = 0; k < MAX_W; k++) begin
         occl_above[k]   = '0;
         occl_center[k]  = '0;
         color_center[k] = '0;
      end
      for (k = 0; k < 9; k++) occl_win[k] = '0;
      color_win[0] = '0;
      color_win[1] = '0;
      col_cnt = 0;
      row_cnt = 0;
   endfunction

   task automatic box_blur_step(pixel_type px);
      int unsigned w, h, c, r, idx;
      bit flush, last_col;
      logic [OCC_W-1:0] top, mid, bot;
      color_type ccol;
      res_type made [2];
      int n, k;
      w = eff_width();
      h = eff_height();
      c = col_cnt;
      r = row_cnt;
      n = 0;
      idx = (c < MAX_W) ? c : MAX_W - 1;
      flush = (r >= h);
      last_col = (c >= w - 1);
      if (r == 0) begin
         occl_center[idx]  = px.occlusion;
         color_center[idx] = px.color;
      end else begin
         mid  = occl_center[idx];
         top  = (r == 1) ? mid : occl_above[idx];
         bot  = flush ? mid : px.occlusion;
         ccol = color_center[idx];
         if (!flush) begin
            occl_above[idx]   = mid;
            occl_center[idx]  = px.occlusion;
            color_center[idx] = px.color;
         end
         if (c == 0) begin
            for (k = 0; k < 3; k++) begin
               occl_win[k * 3 + 0] = top;
               occl_win[k * 3 + 1] = mid;
               occl_win[k * 3 + 2] = bot;
            end
            color_win[0] = ccol;
            color_win[1] = ccol;
         end else begin
            shift_window(top, mid, bot, ccol);
            made[n] = blur_result(1'b0);
            n++;
         end
         if (last_col) begin
            shift_window(occl_win[6], occl_win[7], occl_win[8], color_win[1]);
            made[n] = blur_result(flush);
            n++;
         end
         if (n > 0) made[n - 1].run_last = 1'b1;
         for (k = 0; k < n; k++) modulated_colors.push_back(made[k]);
      end
      if (last_col) begin
         col_cnt = 0;
         row_cnt = flush ? 0 : ((r + 1) & 32'h1FFF);
      end else begin
         col_cnt = (c + 1) & 32'h7FF;
      end
   endtask

   task automatic report_field(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (modulated_colors.size() == 0) begin
            $display("%0t: result expected none, got %h %h %h %b %b", $time, rsp_if.red_out,
                     rsp_if.green_out, rsp_if.blue_out, rsp_if.frame_last, rsp_if.run_last);
            error_count++;
         end else begin
            oldest_color = modulated_colors.pop_front();
            report_field("red_out", oldest_color.red_out, rsp_if.red_out);
            report_field("green_out", oldest_color.green_out, rsp_if.green_out);
            report_field("blue_out", oldest_color.blue_out, rsp_if.blue_out);
            report_field("frame_last", CH_W'(oldest_color.frame_last), CH_W'(rsp_if.frame_last));
            report_field("run_last", CH_W'(oldest_color.run_last), CH_W'(rsp_if.run_last));
         end
      end
   end

   function automatic logic [CH_W-1:0] edge_value(int k);
      case (k % 8)
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'h8001;
         5: return 16'hFFFF;
         6: return 16'h5555;
         default: return 16'hAAAA;
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) px.occlusion = 16'($urandom_range(32768));
      else if (pick < 70) px.occlusion = 16'($urandom_range(65535));
      else if (pick < 85) px.occlusion = edge_value($urandom_range(7));
      else px.occlusion = 16'($urandom_range(32768, 30000));
      px.color.red   = ($urandom_range(9) == 0) ? edge_value($urandom_range(7))
                                                : 16'($urandom_range(65535));
      px.color.green = ($urandom_range(9) == 0) ? edge_value($urandom_range(7))
                                                : 16'($urandom_range(65535));
      px.color.blue  = ($urandom_range(9) == 0) ? edge_value($urandom_range(7))
                                                : 16'($urandom_range(65535));
      px.kind = 1'b0;
      return px;
   endfunction

   task automatic set_idling(int src_pct, int sink_pct);
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
   endtask

   task automatic settle_block();
      while (modulated_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_COUNT) @(posedge clock);
   endtask

   task automatic configure_frame(logic [CSR_DATA_W-1:0] width_data,
                                  logic [CSR_DATA_W-1:0] height_data);
      settle_block();
      csr_if.valid <= 1'b1;
      csr_if.index <= REG_FRAME_WIDTH;
      csr_if.data  <= width_data;
      do @(posedge clock); while (!csr_if.ready);
      cfg_width = width_data[FW_W-1:0];
      csr_if.index <= REG_FRAME_HEIGHT;
      csr_if.data  <= height_data;
      do @(posedge clock); while (!csr_if.ready);
      cfg_height = height_data[FH_W-1:0];
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_pixel(pixel_type px);
      int gap;
      gap = 0;
      while ($urandom_range(99) < src_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.kind      <= px.kind;
      req_if.occlusion <= px.occlusion;
      req_if.red       <= px.color.red;
      req_if.green     <= px.color.green;
      req_if.blue      <= px.color.blue;
      do @(posedge clock); while (!req_if.ready);
      box_blur_step(px);
      pixels_sent++;
   endtask

   // image rows then the padding row, with kind flipped on a few items
   task automatic run_frame(int noise_pct);
      int w, h, r, c;
      bit noisy;
      pixel_type px;
      w = eff_width();
      h = eff_height();
      for (r = 0; r <= h; r++) begin
         for (c = 0; c < w; c++) begin
            px = random_pixel();
            noisy = ($urandom_range(99) < noise_pct);
            px.kind = (r == h) ? !noisy : noisy;
            send_pixel(px);
         end
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic test_directed();
      pixel_type px;
      int r, c, k;
      set_idling(0, 0);
      configure_frame(16'h0000, 16'h0000);
      px.kind = 1'b0;
      px.occlusion = 16'hFFFF;
      px.color = '1;
      send_pixel(px);
      px.kind = 1'b1;
      px.occlusion = '0;
      px.color = '0;
      send_pixel(px);
      req_if.valid <= 1'b0;
      configure_frame(16'd5, 16'd3);
      for (r = 0; r < 4; r++) begin
         for (c = 0; c < 5; c++) begin
            k = r * 5 + c;
            px.kind = (r == 3) ? (c != 1) : (r == 1 && c == 2);
            px.occlusion   = edge_value(k);
            px.color.red   = edge_value(k + 2);
            px.color.green = edge_value(k + 5);
            px.color.blue  = edge_value(k + 1);
            send_pixel(px);
         end
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic test_random_frames();
      int phase, goal, pick;
      logic [CSR_DATA_W-1:0] width_data, height_data;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(72, 0);
            2: set_idling(0, 72);
            default: set_idling(25, 25);
         endcase
         goal = pixels_sent + 330;
         while (pixels_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 5) width_data = '0;
            else if (pick < 70) width_data = 16'($urandom_range(8, 1));
            else if (pick < 92) width_data = 16'($urandom_range(40, 9));
            else width_data = 16'($urandom_range(100, 41));
            pick = $urandom_range(99);
            if (pick < 5) height_data = '0;
            else if (pick < 85) height_data = 16'($urandom_range(4, 1));
            else height_data = 16'($urandom_range(9, 5));
            if ($urandom_range(9) == 0) width_data[15:12] = 4'($urandom_range(15));
            if ($urandom_range(9) == 0) height_data[15:13] = 3'($urandom_range(7));
            configure_frame(width_data, height_data);
            run_frame(10);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.kind      = 1'b0;
      req_if.occlusion = '0;
      req_if.red       = '0;
      req_if.green     = '0;
      req_if.blue      = '0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      reset_blur_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_frames();
      settle_block();
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
